[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[rtl/core/mbp_pkg.sv]
// Package for the modular binomial product block: constants and types.
`default_nettype none
package mbp_pkg;
  localparam int unsigned TableSizeDef = 2048;
  localparam int unsigned MulLat = 3;
  localparam logic [29:0] PrimeMod = 30'd1000000007;
  // Exponent that turns a value into its inverse modulo the prime.
  localparam logic [29:0] InvExp = PrimeMod - 30'd2;
  // Barrett constant floor(2^60 / P) for products below 2^60.
  localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / 64'(PrimeMod));
  localparam logic [10:0] RegTotal = 11'd0;
  localparam logic [10:0] RegMarked = 11'd1;

  typedef enum logic [2:0] {
    BLD_FACT,
    BLD_SQ,
    BLD_MUL,
    BLD_INVF,
    BLD_DONE
  } bld_state_t;
endpackage
`default_nettype wire

[rtl/core/modular_binomial_product.sv]
// Top level of the modular binomial product block.
// For each group count i the block returns C(n-k+1, i) * C(k-1, i-1) mod 1000000007,
// where n (register 0, total_items) and k (register 1, marked_items) come from the
// configuration port; both reset to 1, and writes to other indexes are ignored.
// After reset a build sequence fills the factorial table upward, raises the last
// factorial to the power P-2 by square and multiply, and then fills the inverse
// factorial table downward. Each step waits for the previous product. in_stall
// stays high until the build ends; configuration writes are taken at any time
// (cfg_ready is tied high).
// An input beat is accepted when in_valid is high and in_stall is low. It passes a
// check stage, a table read stage and three levels of three-stage modular multipliers,
// and a new beat may enter in every cycle in which the pipeline is not frozen by
// out_stall.
// When the receiver holds out_stall on a valid result the whole pipeline freezes and
// in_stall rises, so no beat is lost, repeated or changed.
// Queries outside the domain give zero with out_out_of_range set.
`default_nettype none
`include "assert_macros.svh"
module modular_binomial_product import mbp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TableSizeDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [10:0]       in_group_count,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [29:0]            out_ways_mod_p,
  output logic                   out_out_of_range,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [10:0]       cfg_index,
  input  wire logic [10:0]       cfg_data
);
  localparam int unsigned AW = $clog2(TABLE_SIZE);

  logic [29:0] fact_mem [TABLE_SIZE];
  // Two copies of the inverse factorials give four reads per cycle.
  logic [29:0] invf_a_mem [TABLE_SIZE];
  logic [29:0] invf_b_mem [TABLE_SIZE];

  logic [10:0] total_r, marked_r;
  bld_state_t state_r, state_nxt;
  logic [AW:0] idx_r, idx_nxt;
  logic [29:0] acc_r, acc_nxt;
  logic [29:0] base_r, base_nxt;
  logic [4:0] ebit_r, ebit_nxt;
  logic [MulLat-1:0] wv_r;
  logic [29:0] bld_a, bld_b, bld_y;
  logic [AW-1:0] bld_waddr;
  logic bld_issue, bld_busy, bld_done;
  logic fact_we, invf_we;
  logic adv;
  logic run;

  assign cfg_ready = 1'b1;
  assign adv = !out_stall || !out_valid;
  assign run = (state_r == BLD_DONE);
  assign in_stall = !run || !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 11'd1;
      marked_r <= 11'd1;
    end else if (cfg_valid) begin
      if (cfg_index == RegTotal) total_r <= cfg_data;
      else if (cfg_index == RegMarked) marked_r <= cfg_data;
    end
  end

  // Build sequencer. One product is in flight at a time; the next step is issued
  // in the cycle after its result comes back.
  assign bld_busy = |wv_r;
  assign bld_done = wv_r[MulLat-1];

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    acc_nxt = acc_r;
    base_nxt = base_r;
    ebit_nxt = ebit_r;
    bld_issue = 1'b0;
    bld_a = acc_r;
    bld_b = acc_r;
    fact_we = 1'b0;
    invf_we = 1'b0;
    bld_waddr = idx_r[AW-1:0];
    unique case (state_r)
      BLD_FACT: begin
        // Entry 0 multiplies by one so that every entry follows the same step.
        bld_b = (idx_r == '0) ? 30'd1 : 30'(idx_r);
        if (bld_done) begin
          fact_we = 1'b1;
          acc_nxt = bld_y;
          idx_nxt = idx_r + 1'b1;
        end else if (!bld_busy) begin
          if (idx_r == (AW+1)'(TABLE_SIZE)) begin
            base_nxt = acc_r;
            acc_nxt = 30'd1;
            ebit_nxt = 5'd29;
            state_nxt = BLD_SQ;
          end else begin
            bld_issue = 1'b1;
          end
        end
      end
      BLD_SQ: begin
        if (bld_done) begin
          acc_nxt = bld_y;
          if (InvExp[ebit_r]) begin
            state_nxt = BLD_MUL;
          end else if (ebit_r == 5'd0) begin
            invf_we = 1'b1;
            bld_waddr = AW'(TABLE_SIZE - 1);
            idx_nxt = (AW+1)'(TABLE_SIZE - 1);
            state_nxt = BLD_INVF;
          end else begin
            ebit_nxt = ebit_r - 1'b1;
          end
        end else if (!bld_busy) begin
          bld_issue = 1'b1;
        end
      end
      BLD_MUL: begin
        bld_b = base_r;
        if (bld_done) begin
          acc_nxt = bld_y;
          if (ebit_r == 5'd0) begin
            invf_we = 1'b1;
            bld_waddr = AW'(TABLE_SIZE - 1);
            idx_nxt = (AW+1)'(TABLE_SIZE - 1);
            state_nxt = BLD_INVF;
          end else begin
            ebit_nxt = ebit_r - 1'b1;
            state_nxt = BLD_SQ;
          end
        end else if (!bld_busy) begin
          bld_issue = 1'b1;
        end
      end
      BLD_INVF: begin
        // The inverse factorial of idx-1 is that of idx times idx.
        bld_b = 30'(idx_r);
        bld_waddr = AW'(idx_r - 1'b1);
        if (bld_done) begin
          invf_we = 1'b1;
          acc_nxt = bld_y;
          idx_nxt = idx_r - 1'b1;
        end else if (!bld_busy) begin
          if (idx_r == '0) state_nxt = BLD_DONE;
          else bld_issue = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BLD_FACT;
      idx_r <= '0;
      acc_r <= 30'd1;
      base_r <= 30'd1;
      ebit_r <= 5'd29;
      wv_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      acc_r <= acc_nxt;
      base_r <= base_nxt;
      ebit_r <= ebit_nxt;
      wv_r <= {wv_r[MulLat-2:0], bld_issue};
    end
  end

  mbp_mulmod u_bld_mul (.clk(clk), .en(1'b1), .a(bld_a), .b(bld_b), .y(bld_y));

  always_ff @(posedge clk) begin
    if (rst_n && fact_we) fact_mem[bld_waddr] <= bld_y;
    if (rst_n && invf_we) begin
      invf_a_mem[bld_waddr] <= bld_y;
      invf_b_mem[bld_waddr] <= bld_y;
    end
  end

  // Query pipeline. Stage 0: domain checks and index registers.
  logic v0_r, zero0_r, oor0_r;
  logic [AW-1:0] ia0_r, ib0_r, ic0_r, id0_r, ie0_r, if0_r;
  logic [11:0] slots;
  logic oor, zero;
  assign slots = {1'b0, total_r} - {1'b0, marked_r} + 12'd1;

  always_comb begin
    oor = in_group_count == 11'd0 || in_group_count > marked_r || marked_r > total_r;
    if (!oor && (32'(slots) >= TABLE_SIZE || 32'(marked_r - 11'd1) >= TABLE_SIZE))
      oor = 1'b1;
    zero = oor || slots < {1'b0, in_group_count};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid && !in_stall;
    if (adv) begin
      oor0_r <= oor;
      zero0_r <= zero;
      ia0_r <= AW'(slots);
      ib0_r <= AW'(slots - 12'(in_group_count));
      ic0_r <= AW'(in_group_count);
      id0_r <= AW'(marked_r - 11'd1);
      ie0_r <= AW'(marked_r - in_group_count);
      if0_r <= AW'(in_group_count - 11'd1);
    end
  end

  // Stage 1: six table reads, two from each memory.
  logic v1_r, zero1_r, oor1_r;
  logic [29:0] ra_r, rb_r, rc_r, rd_r, re_r, rf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= v0_r;
    if (adv) begin
      zero1_r <= zero0_r; oor1_r <= oor0_r;
      ra_r <= fact_mem[ia0_r]; rb_r <= invf_a_mem[ib0_r]; rc_r <= invf_a_mem[ic0_r];
      rd_r <= fact_mem[id0_r]; re_r <= invf_b_mem[ie0_r]; rf_r <= invf_b_mem[if0_r];
    end
  end

  // Three multiply levels, each MulLat stages, operands delayed alongside.
  logic [29:0] m1a, m1b, m2a, m2b, m3;
  logic [29:0] dc_r [MulLat], df_r [MulLat];
  mbp_mulmod u_m1a (.clk(clk), .en(adv), .a(ra_r), .b(rb_r), .y(m1a));
  mbp_mulmod u_m1b (.clk(clk), .en(adv), .a(rd_r), .b(re_r), .y(m1b));
  always_ff @(posedge clk) begin
    if (adv) begin
      dc_r[0] <= rc_r; df_r[0] <= rf_r;
      for (int s = 1; s < MulLat; s++) begin
        dc_r[s] <= dc_r[s-1]; df_r[s] <= df_r[s-1];
      end
    end
  end
  mbp_mulmod u_m2a (.clk(clk), .en(adv), .a(m1a), .b(dc_r[MulLat-1]), .y(m2a));
  mbp_mulmod u_m2b (.clk(clk), .en(adv), .a(m1b), .b(df_r[MulLat-1]), .y(m2b));
  mbp_mulmod u_m3 (.clk(clk), .en(adv), .a(m2a), .b(m2b), .y(m3));

  localparam int unsigned VD = 3 * MulLat;
  logic [VD-1:0] vp_r, zp_r, op_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= '0;
    else if (adv) vp_r <= {vp_r[VD-2:0], v1_r};
    if (adv) begin
      zp_r <= {zp_r[VD-2:0], zero1_r};
      op_r <= {op_r[VD-2:0], oor1_r};
    end
  end

  assign out_valid = vp_r[VD-1];
  assign out_ways_mod_p = zp_r[VD-1] ? 30'd0 : m3;
  assign out_out_of_range = op_r[VD-1];

  `ASSERT_IMPLY(a_no_in_before_build, clk, rst_n, in_valid && !in_stall, run)
  `ASSERT_IMPLY(a_oor_zero, clk, rst_n, out_valid && out_out_of_range,
    out_ways_mod_p == 30'd0)
  `ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_ways_mod_p))
endmodule
`default_nettype wire

[rtl/core/mbp_mulmod.sv]
// Pipelined modular multiplier: multiply stage, quotient stage, correction stage.
`default_nettype none
module mbp_mulmod import mbp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [29:0] a,
  input  wire logic [29:0] b,
  output logic [29:0]      y
);
  logic [59:0] prod_r;
  logic [30:0] q_r;
  logic [31:0] xlo_r;
  logic [61:0] est;
  logic [31:0] rem;

  // Barrett estimate of the quotient; it is short by at most two.
  assign est = 62'(prod_r[59:29]) * 62'(BarrettMu);

  // The true remainder is below 3P < 2^32, so the low 32 bits suffice.
  always_comb begin
    rem = xlo_r - 32'(32'(q_r) * 32'(PrimeMod));
    if (rem >= 32'(PrimeMod)) rem = rem - 32'(PrimeMod);
    if (rem >= 32'(PrimeMod)) rem = rem - 32'(PrimeMod);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 60'(a) * 60'(b);
      q_r <= est[61:31];
      xlo_r <= prod_r[31:0];
      y <= rem[29:0];
    end
  end
endmodule
`default_nettype wire

[tb/mbp_checker.sv]
// Checker for the modular binomial product block: predicts and compares beats.
module mbp_checker import mbp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [10:0] in_group_count,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [29:0] out_ways_mod_p,
  input  wire logic        out_out_of_range,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [10:0] cfg_index,
  input  wire logic [10:0] cfg_data,
  output int               fail_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned Prime = 64'd1000000007;
  localparam int unsigned Depth = TableSizeDef;

  typedef struct packed {
    logic [29:0] ways;
    logic        oor;
  } ways_t;

  longint unsigned fact_q [Depth];
  longint unsigned inv_q [Depth];
  longint unsigned invf_q [Depth];
  logic [10:0] total_n;
  logic [10:0] marked_k;
  ways_t expected_ways [$];

  initial begin
    fact_q[0] = 1; fact_q[1] = 1;
    inv_q[0] = 1; inv_q[1] = 1;
    invf_q[0] = 1; invf_q[1] = 1;
    for (int j = 2; j < Depth; j++) begin
      fact_q[j] = (longint'(j) * fact_q[j-1]) % Prime;
      inv_q[j] = (inv_q[Prime % j] * (Prime - Prime / j)) % Prime;
      invf_q[j] = (invf_q[j-1] * inv_q[j]) % Prime;
    end
  end

  function automatic longint unsigned choose(longint unsigned top, longint unsigned pick);
    return (((fact_q[top] * invf_q[top-pick]) % Prime) * invf_q[pick]) % Prime;
  endfunction

  function automatic ways_t predict_ways(logic [10:0] grp);
    ways_t r;
    longint unsigned i, n, k, slots;
    i = grp; n = total_n; k = marked_k;
    r = '0;
    if (i < 1 || i > k || k > n) begin
      r.oor = 1'b1;
      return r;
    end
    slots = n - k + 1;
    if (slots >= Depth || k - 1 >= Depth) begin
      r.oor = 1'b1;
      return r;
    end
    if (slots < i) return r;
    r.ways = 30'((choose(slots, i) * choose(k - 1, i - 1)) % Prime);
    return r;
  endfunction

  assign pending_count = expected_ways.size();

  always @(posedge clk) begin
    ways_t e;
    if (!rst_n) begin
      total_n <= 11'd1;
      marked_k <= 11'd1;
      fail_count <= 0;
      expected_ways.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegTotal) total_n <= cfg_data;
        else if (cfg_index == RegMarked) marked_k <= cfg_data;
      end
      if (in_valid && !in_stall)
        expected_ways.insert(expected_ways.size(), predict_ways(in_group_count));
      if (out_valid && !out_stall) begin
        if (expected_ways.size() == 0) begin
          $display("%0t: unexpected beat ways=%0d oor=%0b", $time, out_ways_mod_p,
                   out_out_of_range);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_ways.pop_front();
          if (e.ways !== out_ways_mod_p || e.oor !== out_out_of_range) begin
            $display("%0t: mismatch expected ways=%0d oor=%0b actual ways=%0d oor=%0b",
                     $time, e.ways, e.oor, out_ways_mod_p, out_out_of_range);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/tb_modular_binomial_product.sv]
// Testbench top: drives stimulus and configuration phases, gives the verdict.
module tb_modular_binomial_product import mbp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 100000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [10:0] in_group_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [29:0] out_ways_mod_p;
  logic out_out_of_range;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;
  int fail_count, pending_count;
  int idle_cycles = 0;
  int stall_mode = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modular_binomial_product dut (.*);

  mbp_checker checker_i (.*);

  // The receiver stalls on its own pattern: a mode that changes now and then picks
  // between no stalls, light random stalls, heavy stalls and stalls that toggle at random.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 15) < 8) ? out_stall : ~out_stall;
    endcase
  end

  // The watchdog ends the run when no beat is accepted on any channel for too long.
  // The build pass after reset stays well under the limit.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("** modular_binomial_product: FAILED **");
      $finish;
    end
  end

  // One configuration beat, written only while the block has nothing in flight.
  task automatic write_reg(input logic [10:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one group count beat and holds it until the block takes it. Valid stays
  // high across back-to-back beats; gaps are inserted only between bursts.
  task automatic send_group(input logic [10:0] grp);
    in_valid <= 1'b1;
    in_group_count <= grp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Waits until every expected beat has come back, then lets the pipeline drain.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // A group count biased toward the range 1 to k and its edges at zero and k+1.
  function automatic logic [10:0] pick_group(input logic [10:0] k);
    case ($urandom_range(0, 9))
      0: return 11'($urandom_range(0, 2047));
      1: return 11'd0;
      2: return k;
      3: return 11'(k + 1);
      default: return 11'($urandom_range(1, (k == 0) ? 1 : k));
    endcase
  endfunction

  initial begin
    logic [10:0] n, k;
    int sent, burst;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset values (n = k = 1): zero, one, above k, all ones.
    send_group(11'd0);
    send_group(11'd1);
    send_group(11'd2);
    send_group(11'h7FF);
    drain();

    // Extremes: n = k = 2047, marked above total, too few slots, unknown index.
    write_reg(RegTotal, 11'h7FF);
    write_reg(RegMarked, 11'h7FF);
    send_group(11'd1);
    send_group(11'h7FF);
    send_group(11'd1024);
    send_group(11'd0);
    drain();
    write_reg(RegTotal, 11'd5);
    write_reg(RegMarked, 11'd6);
    send_group(11'd1);
    send_group(11'd3);
    drain();
    write_reg(RegTotal, 11'd10);
    write_reg(RegMarked, 11'd8);
    write_reg(11'd2, 11'd3);
    write_reg(11'h7FF, 11'h7FF);
    send_group(11'd3);
    send_group(11'd4);
    send_group(11'd2);
    send_group(11'd8);
    send_group(11'd9);
    drain();
    write_reg(RegTotal, 11'h7FF);
    write_reg(RegMarked, 11'd1);
    send_group(11'd1);
    send_group(11'd2);
    drain();
    write_reg(RegTotal, 11'd0);
    write_reg(RegMarked, 11'd0);
    send_group(11'd0);
    send_group(11'd1);
    drain();

    // Random phases: each picks a setting, then sends bursts with random content.
    sent = 0;
    while (sent < 900) begin
      case ($urandom_range(0, 5))
        0: n = 11'h7FF;
        1: n = 11'($urandom_range(1, 40));
        default: n = 11'($urandom_range(0, 2047));
      endcase
      if ($urandom_range(0, 7) == 0) k = 11'($urandom_range(0, 2047));
      else k = 11'($urandom_range(0, n));
      write_reg(RegTotal, n);
      write_reg(RegMarked, k);
      for (int b = 0; b < 6; b++) begin
        burst = $urandom_range(1, 20);
        for (int j = 0; j < burst; j++) begin
          send_group(pick_group(k));
          sent++;
        end
        if ($urandom_range(0, 2) != 0) pause_sender();
      end
      drain();
    end

    if (fail_count == 0)
      $display("** modular_binomial_product: PASSED **");
    else
      $display("** modular_binomial_product: FAILED **");
    $finish;
  end
endmodule

[modular_binomial_product.f]
+incdir+rtl/core
rtl/core/mbp_pkg.sv
rtl/core/mbp_mulmod.sv
rtl/core/modular_binomial_product.sv
tb/mbp_checker.sv
tb/tb_modular_binomial_product.sv
